// ----- hdl/sotr_pkg.sv -----
// Shared types and codes for the stop order trigger table.
`default_nettype none
package sotr_pkg;

    localparam int IDX_W       = 6;   // slot index, covers up to 64 slots
    localparam int CNT_W       = 7;   // rank, scan step and result counters
    localparam int MAX_RESULTS = 16;

    // request codes
    localparam logic [1:0] REQ_PLACE      = 2'd0;
    localparam logic [1:0] REQ_CANCEL_REF = 2'd1;
    localparam logic [1:0] REQ_CANCEL_STR = 2'd2;
    localparam logic [1:0] REQ_TICK       = 2'd3;

    // order kinds
    localparam logic [1:0] KIND_BUY   = 2'd0;
    localparam logic [1:0] KIND_SELL  = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;
    localparam logic [1:0] KIND_COVER = 2'd3;

    // result status codes
    localparam logic [2:0] ST_PLACED    = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_TRIGGERED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_NO_FIRE   = 3'd5;

    typedef struct packed {
        logic [15:0] instrument;
        logic [1:0]  kind;
        logic [30:0] price;
        logic [15:0] quantity;
        logic [7:0]  strategy;
        logic [31:0] sref;
    } slot_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] instrument;
        logic [30:0] price;
        logic [7:0]  strategy;
        logic [31:0] target;
    } cell_req_t;

    typedef struct packed {
        logic             load;   // latch selection and seed the ring
        logic             shift;  // advance the ring one cell
        logic             emit;   // remove the cell holding the current rank
        logic [CNT_W-1:0] rank;   // rank being emitted
    } cell_ctl_t;

    typedef struct packed {
        logic             sel;
        logic [31:0]      sref;
        logic [IDX_W-1:0] idx;
    } ring_t;

    typedef struct packed {
        logic  valid;
        logic  hit_cur;
        logic  hit_nxt;
        slot_t data;     // zero unless hit_cur
    } cell_stat_t;

    function automatic logic kind_sells(input logic [1:0] kind);
        return (kind == KIND_SELL) || (kind == KIND_SHORT);
    endfunction

    function automatic logic kind_closes(input logic [1:0] kind);
        return (kind == KIND_SELL) || (kind == KIND_COVER);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sotr_cell.sv -----
// One slot of the table: order storage, selection and rank counting on the ring.
`default_nettype none
module sotr_cell import sotr_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctl_t  ctl,
    input  wire cell_req_t  req,
    input  wire logic       wr_en,
    input  wire slot_t      wr_data,
    input  wire ring_t      ring_in,
    output ring_t           ring_out,
    output cell_stat_t      stat
);

    logic             valid_reg, valid_next;
    logic             sel_reg, sel_next;
    slot_t            slot_reg;
    logic [CNT_W-1:0] rank_reg, rank_next;
    ring_t            ring_reg, ring_next;
    logic             sel_comb;
    logic             fire;
    logic             earlier;

    always_comb begin
        fire = kind_sells(slot_reg.kind) ? (req.price <= slot_reg.price)
                                         : (req.price >= slot_reg.price);
        case (req.req)
            REQ_CANCEL_REF: sel_comb = valid_reg && (slot_reg.sref == req.target);
            REQ_CANCEL_STR: sel_comb = valid_reg && (slot_reg.strategy == req.strategy);
            REQ_TICK:       sel_comb = valid_reg && (slot_reg.instrument == req.instrument)
                                       && fire;
            default:        sel_comb = 1'b0;
        endcase
    end

    // passing word sorts ahead of ours: lower reference, ties by slot index
    assign earlier = ring_in.sel &&
                     ((ring_in.sref < slot_reg.sref) ||
                      ((ring_in.sref == slot_reg.sref) &&
                       (ring_in.idx < IDX_W'(CELL_IDX))));

    assign stat.hit_cur = sel_reg && (rank_reg == ctl.rank);
    assign stat.hit_nxt = sel_reg && (rank_reg == ctl.rank + CNT_W'(1));
    assign stat.valid   = valid_reg;
    assign stat.data    = stat.hit_cur ? slot_reg : '0;
    assign ring_out     = ring_reg;

    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        rank_next  = rank_reg;
        ring_next  = ring_reg;
        if (wr_en) begin
            valid_next = 1'b1;
        end
        if (ctl.load) begin
            sel_next       = sel_comb;
            rank_next      = '0;
            ring_next.sel  = sel_comb;
            ring_next.sref = slot_reg.sref;
            ring_next.idx  = IDX_W'(CELL_IDX);
        end
        if (ctl.shift) begin
            ring_next = ring_in;
            if (earlier) begin
                rank_next = rank_reg + CNT_W'(1);
            end
        end
        // drop the order as its result is loaded into the result register
        if (ctl.emit && stat.hit_cur) begin
            valid_next = 1'b0;
            sel_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
        rank_reg <= rank_next;
        ring_reg <= ring_next;
        if (wr_en) begin
            slot_reg <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/stop_order_trigger_table.sv -----
// Top level of the stop order trigger table: request sequencer, cell row and result register.
//
//  channel | ports              | word
//  input   | s_tvalid/s_tready  | s_tuser req_type, s_tdata order fields
//  result  | m_tvalid/m_tready  | m_tuser status, m_tdata order fields, m_tlast
//
// One request at a time. Place holds the input through accept, then slot pick and result
// load, which waits for a free result register; its result is offered from the next cycle.
// Cancel and tick give n result words, n being 1 when nothing is removed or fired:
// the stored references circulate once round the row of cells so each cell learns its
// rank, then one result leaves per cycle while the result register is free. A stalled
// result register holds the sequencer. Reset clears all valid bits and the reference counter at once.
`default_nettype none
module stop_order_trigger_table import sotr_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // instrument_id, order_kind, price_ticks, quantity, strategy_id,
    // target_ref, upper_limit, lower_limit
    input  wire logic [167:0] s_tdata,
    // req_type
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // reference, out_strategy, out_kind, is_sell, is_close, order_price,
    // out_quantity
    output logic [95:0]       m_tdata,
    // status
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_RANK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [31:0]      ref_cnt_reg, ref_cnt_next;
    cell_req_t        req_reg;
    logic [15:0]      qty_reg;
    logic [1:0]       kind_reg;
    logic [30:0]      upper_reg, lower_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [95:0]      m_tdata_reg, m_tdata_next;
    logic [2:0]       m_tuser_reg, m_tuser_next;
    logic             m_tlast_reg, m_tlast_next;

    cell_ctl_t        ctl;
    cell_stat_t       stat [TABLE_DEPTH];
    ring_t            ring [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] wr_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    slot_t            wr_data;
    slot_t            hit_data;
    logic             any_hit, any_nxt, any_free;
    logic [CNT_W-1:0] cap;
    logic             out_free, accept;
    logic             last_res;
    logic [30:0]      res_price;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign wr_data.instrument = req_reg.instrument;
    assign wr_data.kind       = kind_reg;
    assign wr_data.price      = req_reg.price;
    assign wr_data.quantity   = qty_reg;
    assign wr_data.strategy   = req_reg.strategy;
    assign wr_data.sref       = ref_cnt_reg + 32'd1;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            sotr_cell #(.CELL_IDX(g)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .req      (req_reg),
                .wr_en    (wr_vec[g]),
                .wr_data  (wr_data),
                .ring_in  (ring[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
                .ring_out (ring[g]),
                .stat     (stat[g])
            );
            assign hit_vec[g] = stat[g].hit_cur;
        end
    endgenerate

    // lowest free slot and merge of the emitting cell
    always_comb begin
        logic found;
        found    = 1'b0;
        wr_vec   = '0;
        any_nxt  = 1'b0;
        hit_data = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!stat[i].valid && !found) begin
                wr_vec[i] = 1'b1;
                found     = 1'b1;
            end
            any_nxt  = any_nxt | stat[i].hit_nxt;
            hit_data = hit_data | stat[i].data;
        end
        any_free = found;
        any_hit  = |hit_vec;
        // only write when the placement actually goes ahead
        if (!(state_reg == S_SEL && req_reg.req == REQ_PLACE && out_free)) begin
            wr_vec = '0;
        end
    end

    assign cap       = (req_reg.req == REQ_CANCEL_REF) ? CNT_W'(1) : CNT_W'(MAX_RESULTS);
    assign last_res  = !any_nxt || (rank_reg + CNT_W'(1) == cap);
    assign res_price = (req_reg.req == REQ_TICK)
                     ? (kind_sells(hit_data.kind) ? lower_reg : upper_reg)
                     : hit_data.price;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        rank_next     = rank_reg;
        ref_cnt_next  = ref_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ctl           = '0;
        ctl.rank      = rank_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SEL;
                end
            end
            S_SEL: begin
                if (req_reg.req == REQ_PLACE) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b1;
                        if (any_free) begin
                            ref_cnt_next = ref_cnt_reg + 32'd1;
                            m_tuser_next = ST_PLACED;
                            m_tdata_next = {5'd0, qty_reg, req_reg.price,
                                            kind_closes(kind_reg), kind_sells(kind_reg),
                                            kind_reg, req_reg.strategy, ref_cnt_next};
                        end else begin
                            m_tuser_next = ST_FULL;
                            m_tdata_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end else begin
                    ctl.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_RANK;
                end
            end
            S_RANK: begin
                if (step_reg == CNT_W'(TABLE_DEPTH - 1)) begin
                    rank_next  = '0;
                    state_next = S_EMIT;
                end else begin
                    ctl.shift = 1'b1;
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (any_hit) begin
                        ctl.emit     = 1'b1;
                        m_tuser_next = (req_reg.req == REQ_TICK) ? ST_TRIGGERED
                                                                 : ST_CANCELLED;
                        m_tdata_next = {5'd0, hit_data.quantity, res_price,
                                        kind_closes(hit_data.kind),
                                        kind_sells(hit_data.kind), hit_data.kind,
                                        hit_data.strategy, hit_data.sref};
                        m_tlast_next = last_res;
                        rank_next    = rank_reg + CNT_W'(1);
                        if (last_res) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        // nothing selected at all
                        m_tlast_next = 1'b1;
                        m_tdata_next = '0;
                        case (req_reg.req)
                            REQ_CANCEL_REF: begin
                                m_tuser_next       = ST_NOT_FOUND;
                                m_tdata_next[31:0] = req_reg.target;
                            end
                            REQ_CANCEL_STR: begin
                                m_tuser_next        = ST_NOT_FOUND;
                                m_tdata_next[39:32] = req_reg.strategy;
                            end
                            default: m_tuser_next = ST_NO_FIRE;
                        endcase
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ref_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ref_cnt_reg  <= ref_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        step_reg    <= step_next;
        rank_reg    <= rank_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (accept) begin
            req_reg.req        <= s_tuser;
            req_reg.instrument <= s_tdata[15:0];
            kind_reg           <= s_tdata[17:16];
            req_reg.price      <= s_tdata[48:18];
            qty_reg            <= s_tdata[64:49];
            req_reg.strategy   <= s_tdata[72:65];
            req_reg.target     <= s_tdata[104:73];
            upper_reg          <= s_tdata[135:105];
            lower_reg          <= s_tdata[166:136];
        end
    end

    // at most one cell may claim a given rank
    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> $onehot0(hit_vec))
        else $error("several cells hold the same rank");

    // the sequencer leaves idle only on an accepted word
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !accept) |=> state_reg == S_IDLE)
        else $error("sequencer left idle without a request");

    // the reference counter moves only with a successful placement
    a_ref_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_cnt_reg != ref_cnt_next) |-> (|wr_vec))
        else $error("reference counter moved without a placement");

endmodule
`default_nettype wire

// ----- verif/stop_order_checker.sv -----
// Checker for the stop order trigger table: predicts every result word and compares it.
`timescale 1ns / 1ps
module stop_order_checker import sotr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [167:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [95:0]  m_tdata,
    input  wire logic [2:0]   m_tuser,
    input  wire logic         m_tlast,
    output int                fail_count,
    output int                pending,
    output int                words_seen
);

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] oref;
        logic [7:0]  strategy;
        logic [1:0]  kind;
        logic        sell;
        logic        close;
        logic [30:0] price;
        logic [15:0] quantity;
        logic        last;
    } order_result_t;

    order_result_t result_queue[$];

    logic        book_live[DEPTH];
    logic [15:0] book_instr[DEPTH];
    logic [1:0]  book_kind[DEPTH];
    logic [30:0] book_price[DEPTH];
    logic [15:0] book_qty[DEPTH];
    logic [7:0]  book_strat[DEPTH];
    logic [31:0] book_ref[DEPTH];
    logic [31:0] next_ref;

    function automatic order_result_t order_word(input logic [2:0] st, input int i,
                                                 input logic [30:0] price);
        order_result_t r;
        r.status   = st;
        r.oref     = book_ref[i];
        r.strategy = book_strat[i];
        r.kind     = book_kind[i];
        r.sell     = (book_kind[i] == KIND_SELL) || (book_kind[i] == KIND_SHORT);
        r.close    = (book_kind[i] == KIND_SELL) || (book_kind[i] == KIND_COVER);
        r.price    = price;
        r.quantity = book_qty[i];
        r.last     = 1'b0;
        return r;
    endfunction

    // Emit up to MAX_RESULTS picked orders in ascending reference order and take them off the book.
    task automatic drain_book(inout logic pick[DEPTH], input logic [2:0] st,
                              input logic use_limits, input logic [30:0] upper,
                              input logic [30:0] lower);
        int best;
        int n;
        logic [30:0] px;
        n = 0;
        while (n < MAX_RESULTS) begin
            best = -1;
            for (int i = 0; i < DEPTH; i++)
                if (pick[i] && (best < 0 || book_ref[i] < book_ref[best])) best = i;
            if (best < 0) break;
            px = book_price[best];
            if (use_limits)
                px = ((book_kind[best] == KIND_SELL) || (book_kind[best] == KIND_SHORT))
                     ? lower : upper;
            result_queue = {result_queue, order_word(st, best, px)};
            pick[best] = 1'b0;
            book_live[best] = 1'b0;
            n++;
        end
    endtask

    task automatic predict_request(input logic [1:0] req, input logic [167:0] d);
        logic [15:0] instr;
        logic [1:0]  kind;
        logic [30:0] price;
        logic [15:0] qty;
        logic [7:0]  strat;
        logic [31:0] target;
        logic [30:0] upper;
        logic [30:0] lower;
        logic        pick[DEPTH];
        logic        any;
        int          hit;
        order_result_t r;
        instr  = d[15:0];
        kind   = d[17:16];
        price  = d[48:18];
        qty    = d[64:49];
        strat  = d[72:65];
        target = d[104:73];
        upper  = d[135:105];
        lower  = d[166:136];
        any    = 1'b0;
        hit    = -1;
        r      = '0;
        for (int i = 0; i < DEPTH; i++) pick[i] = 1'b0;
        case (req)
            REQ_PLACE: begin
                for (int i = DEPTH - 1; i >= 0; i--) if (!book_live[i]) hit = i;
                if (hit < 0) begin
                    r.status = ST_FULL;
                    result_queue = {result_queue, r};
                end else begin
                    next_ref = next_ref + 1;
                    book_live[hit]  = 1'b1;
                    book_instr[hit] = instr;
                    book_kind[hit]  = kind;
                    book_price[hit] = price;
                    book_qty[hit]   = qty;
                    book_strat[hit] = strat;
                    book_ref[hit]   = next_ref;
                    result_queue = {result_queue, order_word(ST_PLACED, hit, price)};
                end
            end
            REQ_CANCEL_REF: begin
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (book_live[i] && book_ref[i] == target) hit = i;
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                    r.oref   = target;
                    result_queue = {result_queue, r};
                end else begin
                    result_queue = {result_queue,
                                    order_word(ST_CANCELLED, hit, book_price[hit])};
                    book_live[hit] = 1'b0;
                end
            end
            REQ_CANCEL_STR: begin
                for (int i = 0; i < DEPTH; i++)
                    if (book_live[i] && book_strat[i] == strat) begin
                        pick[i] = 1'b1;
                        any = 1'b1;
                    end
                if (any) drain_book(pick, ST_CANCELLED, 1'b0, '0, '0);
                else begin
                    r.status   = ST_NOT_FOUND;
                    r.strategy = strat;
                    result_queue = {result_queue, r};
                end
            end
            default: begin
                for (int i = 0; i < DEPTH; i++)
                    if (book_live[i] && book_instr[i] == instr) begin
                        if (((book_kind[i] == KIND_SELL) || (book_kind[i] == KIND_SHORT))
                            ? (price <= book_price[i]) : (price >= book_price[i])) begin
                            pick[i] = 1'b1;
                            any = 1'b1;
                        end
                    end
                if (any) drain_book(pick, ST_TRIGGERED, 1'b1, upper, lower);
                else begin
                    r.status = ST_NO_FIRE;
                    result_queue = {result_queue, r};
                end
            end
        endcase
        result_queue[$].last = 1'b1;
    endtask

    task automatic compare_word();
        order_result_t e;
        if (result_queue.size() == 0) begin
            $error("result word with nothing expected: status %0d ref %0d", m_tuser,
                   m_tdata[31:0]);
            fail_count++;
            return;
        end
        e = result_queue.pop_front();
        if (m_tuser != e.status) begin
            $error("status: expected %0d actual %0d", e.status, m_tuser); fail_count++;
        end
        if (m_tdata[31:0] != e.oref) begin
            $error("reference: expected %0d actual %0d", e.oref, m_tdata[31:0]); fail_count++;
        end
        if (m_tdata[39:32] != e.strategy) begin
            $error("out_strategy: expected %0d actual %0d", e.strategy, m_tdata[39:32]);
            fail_count++;
        end
        if (m_tdata[41:40] != e.kind) begin
            $error("out_kind: expected %0d actual %0d", e.kind, m_tdata[41:40]); fail_count++;
        end
        if (m_tdata[42] != e.sell) begin
            $error("is_sell: expected %0d actual %0d", e.sell, m_tdata[42]); fail_count++;
        end
        if (m_tdata[43] != e.close) begin
            $error("is_close: expected %0d actual %0d", e.close, m_tdata[43]); fail_count++;
        end
        if (m_tdata[74:44] != e.price) begin
            $error("order_price: expected %0d actual %0d", e.price, m_tdata[74:44]);
            fail_count++;
        end
        if (m_tdata[90:75] != e.quantity) begin
            $error("out_quantity: expected %0d actual %0d", e.quantity, m_tdata[90:75]);
            fail_count++;
        end
        if (m_tlast != e.last) begin
            $error("last: expected %0d actual %0d", e.last, m_tlast); fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        words_seen = 0;
        next_ref   = '0;
        for (int i = 0; i < DEPTH; i++) book_live[i] = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                compare_word();
                words_seen++;
            end
        end
        pending = result_queue.size();
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the stop order trigger table testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import sotr_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           words_seen;
    int           cycle_count;
    int           places;
    int           cancels;
    int           ticks;
    logic         long_hold;
    logic         hold_done;
    logic [31:0]  ref_guess;

    stop_order_trigger_table dut (.*);

    stop_order_checker chk (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: stall pattern whose mode is redrawn when a phase counter runs out, plus one long hold-off.
    always @(posedge aclk) begin
        int phase_left;
        int stall_mode;
        int hold_left;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            phase_left = 0;
            stall_mode = 0;
            hold_left  = 0;
            hold_done  <= 1'b0;
        end else if (long_hold && !hold_done && hold_left == 0) begin
            hold_left = 400;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = 64;
                stall_mode = $urandom_range(0, 2);
            end
            phase_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 600000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send(input logic [1:0] req, input logic [15:0] instr,
                        input logic [1:0] kind, input logic [30:0] price,
                        input logic [15:0] qty, input logic [7:0] strat,
                        input logic [31:0] target, input logic [30:0] upper,
                        input logic [30:0] lower);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, lower, upper, target, strat, qty, price, kind, instr};
        case (req)
            REQ_PLACE: begin places++; ref_guess++; end
            REQ_TICK: ticks++;
            default: cancels++;
        endcase
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid only for a real gap
    task automatic idle(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Random request biased towards a small set of instruments and strategies.
    task automatic random_request();
        int          pick;
        logic [15:0] instr;
        logic [30:0] price;
        logic [7:0]  strat;
        logic [31:0] target;
        pick  = $urandom_range(0, 99);
        instr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        price = ($urandom_range(0, 19) == 0) ? 31'($urandom)
                : 31'(1000 + $urandom_range(0, 80) - 40);
        strat = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        target = ($urandom_range(0, 7) == 0) ? $urandom
                 : $urandom_range(0, ref_guess + 2);
        if (pick < 42)
            send(REQ_PLACE, instr, 2'($urandom), price, 16'($urandom), strat,
                 $urandom, 31'($urandom), 31'($urandom));
        else if (pick < 77)
            send(REQ_TICK, instr, 2'($urandom), price, 16'($urandom), strat,
                 $urandom, 31'($urandom), 31'($urandom));
        else if (pick < 92)
            send(REQ_CANCEL_REF, instr, 2'($urandom), price, 16'($urandom), strat,
                 target, 31'($urandom), 31'($urandom));
        else
            send(REQ_CANCEL_STR, instr, 2'($urandom), price, 16'($urandom), strat,
                 $urandom, 31'($urandom), 31'($urandom));
    endtask

    initial begin
        int burst;
        int total;
        cycle_count = 0;
        places      = 0;
        cancels     = 0;
        ticks       = 0;
        ref_guess   = '0;
        long_hold   = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_PLACE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes of every field, all kinds
        send(REQ_PLACE, 16'h0000, KIND_BUY, 31'h0, 16'h0000, 8'h00, '0, '0, '0);
        send(REQ_PLACE, 16'hFFFF, KIND_SELL, 31'h7FFFFFFF, 16'hFFFF, 8'hFF, '1, '1, '1);
        send(REQ_PLACE, 16'h0000, KIND_SHORT, 31'd500, 16'd7, 8'hFF, '0, '0, '0);
        send(REQ_PLACE, 16'h0000, KIND_COVER, 31'd500, 16'd9, 8'h01, '0, '0, '0);
        send(REQ_CANCEL_REF, '0, '0, '0, '0, '0, 32'hFFFFFFFF, '0, '0);   // unknown
        send(REQ_CANCEL_REF, '0, '0, '0, '0, '0, 32'd3, '0, '0);
        send(REQ_CANCEL_STR, '0, '0, '0, '0, 8'h77, '0, '0, '0);          // no orders
        send(REQ_TICK, 16'd4242, '0, 31'd500, '0, '0, '0, '1, '0);        // nothing fires
        send(REQ_TICK, 16'h0000, '0, 31'd500, '0, '0, '0, 31'h7FFFFFFF, 31'h0);
        send(REQ_TICK, 16'hFFFF, '0, 31'h7FFFFFFF, '0, '0, '0, 31'h0, 31'h7FFFFFFF);
        idle(3);
        // fill the book, hit the full case, then drain one strategy
        for (int i = 0; i < 16; i++)
            send(REQ_PLACE, 16'd1, 2'(i), 31'(100 + i), 16'(i), 8'(i % 2), '0, '0, '0);
        send(REQ_PLACE, 16'd1, KIND_BUY, 31'd1, 16'd1, 8'd5, '0, '0, '0);
        send(REQ_CANCEL_STR, '0, '0, '0, '0, 8'd0, '0, '0, '0);
        send(REQ_TICK, 16'd1, '0, 31'd108, '0, '0, '0, 31'd999, 31'd11);
        idle(2);

        total = 0;
        while (total < 240) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) random_request();
            total += burst;
            if (total > 90 && !long_hold) long_hold <= 1'b1;   // long receiver stall
            if (total > 180 && total - burst <= 180) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("covered %0d places, %0d cancels, %0d ticks; %0d result words checked",
                 places, cancels, ticks, words_seen);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- stop_order_trigger_table.f -----
hdl/sotr_pkg.sv
hdl/sotr_cell.sv
hdl/stop_order_trigger_table.sv
verif/stop_order_checker.sv
verif/testbench.sv
